// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising edge of clk once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check without the reset qualifier.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies.
package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_REAR,
    CMD_POP_FRONT,
    CMD_POP_REAR,
    CMD_ROTATE
  } cell_cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic  valid;
    word_t word;
  } link_t;

endpackage

// File: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: command decode, list walker, result register.
// Depends on deq_pkg and deq_chain.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | start, busy          | in_opcode, in_push_value
//  result   | out_strobe           | out_result_value, out_status, out_last_of_run
//
// Push and pop are single beats: a beat accepted at one edge shows its result on
// the next cycle, and busy stays low, so such beats may follow every cycle.
// List of N words holds busy while the cell row rotates one step per cycle toward
// the front; the N results are registered and stream out behind the steps. After N
// steps the row is back in its original order. Empty list: one ST_EMPTY beat.
// Reset clears valid bits, the count and the walker; stored words are kept.
// The receiver cannot stall: every strobed beat is taken in its cycle.
module double_ended_queue import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  word_t       in_push_value,
  output logic        out_strobe,
  output word_t       out_result_value,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);

  cell_cmd_t cmd;
  link_t     front;
  word_t     rear_word;
  logic      empty, full;
  logic      accept;

  logic      listing_r, listing_nxt;
  cnt_t      remain_r, remain_nxt;
  cnt_t      count_r, count_nxt;
  logic      strobe_r, strobe_nxt;
  word_t     value_r, value_nxt;
  status_t   status_r, status_nxt;
  logic      last_r, last_nxt;

  assign accept = start && !listing_r;
  assign busy   = listing_r;

  deq_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_push_value),
    .front      (front),
    .rear_word  (rear_word),
    .empty      (empty),
    .full       (full)
  );

  always_comb begin
    cmd         = CMD_HOLD;
    listing_nxt = listing_r;
    remain_nxt  = remain_r;
    count_nxt   = count_r;
    strobe_nxt  = 1'b0;
    value_nxt   = '0;
    status_nxt  = ST_OK;
    last_nxt    = 1'b1;

    if (listing_r) begin
      // emit the head word, then rotate it to the rear
      cmd         = CMD_ROTATE;
      strobe_nxt  = 1'b1;
      value_nxt   = front.word;
      last_nxt    = (remain_r == cnt_t'(1));
      remain_nxt  = remain_r - cnt_t'(1);
      listing_nxt = (remain_r != cnt_t'(1));
    end else if (accept) begin
      case (in_opcode)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          strobe_nxt = 1'b1;
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd       = (in_opcode == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          strobe_nxt = 1'b1;
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (in_opcode == OP_POP_FRONT) begin
            cmd       = CMD_POP_FRONT;
            value_nxt = front.word;
            count_nxt = count_r - cnt_t'(1);
          end else begin
            cmd       = CMD_POP_REAR;
            value_nxt = rear_word;
            count_nxt = count_r - cnt_t'(1);
          end
        end
        OP_LIST: begin
          if (empty) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_EMPTY;
          end else begin
            listing_nxt = 1'b1;
            remain_nxt  = count_r;
          end
        end
        default: ;  // drop unused opcodes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listing_r <= 1'b0;
      remain_r  <= '0;
      count_r   <= '0;
      strobe_r  <= 1'b0;
    end else begin
      listing_r <= listing_nxt;
      remain_r  <= remain_nxt;
      count_r   <= count_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_result_value = value_r;
  assign out_status       = status_r;
  assign out_last_of_run  = last_r;

endmodule

// File: hw/rtl/deq_cell.sv
// One storage cell of the queue row: a word and its valid bit.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  word_t     push_value,
  input  word_t     head_word,
  input  link_t     prev,
  input  link_t     next,
  output link_t     q
);

  logic  valid_r, valid_nxt;
  word_t word_r, word_nxt;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    case (cmd)
      CMD_PUSH_FRONT: begin
        valid_nxt = prev.valid;
        word_nxt  = prev.word;
      end
      CMD_PUSH_REAR: begin
        // first empty cell behind a filled one takes the word
        if (!valid_r && prev.valid) begin
          valid_nxt = 1'b1;
          word_nxt  = push_value;
        end
      end
      CMD_POP_FRONT: begin
        valid_nxt = next.valid;
        word_nxt  = next.word;
      end
      CMD_POP_REAR: begin
        if (!next.valid) valid_nxt = 1'b0;
      end
      CMD_ROTATE: begin
        // advance toward the front; the rear cell takes the old head
        if (valid_r) word_nxt = next.valid ? next.word : head_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = '{valid: valid_r, word: word_r};

endmodule

// File: hw/rtl/deq_chain.sv
// Row of DEPTH queue cells, front at cell 0, plus the rear-word select.
// Depends on deq_pkg and deq_cell.
module deq_chain import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  word_t     push_value,
  output link_t     front,
  output word_t     rear_word,
  output logic      empty,
  output logic      full
);

  link_t cell_q [DEPTH];
  link_t head_link;
  link_t tail_link;

  assign head_link = '{valid: 1'b1, word: push_value};
  assign tail_link = '{valid: 1'b0, word: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t prev_l, next_l;
    if (i == 0) begin : g_head
      assign prev_l = head_link;
    end else begin : g_mid
      assign prev_l = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_l = tail_link;
    end else begin : g_body
      assign next_l = cell_q[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .push_value (push_value),
      .head_word  (cell_q[0].word),
      .prev       (prev_l),
      .next       (next_l),
      .q          (cell_q[i])
    );
  end

  // The rear word sits in the one valid cell whose successor is empty, or in the last cell when the row is full.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (cell_q[i].valid && !cell_q[i+1].valid) rear_word = rear_word | cell_q[i].word;
    end
    if (cell_q[DEPTH-1].valid) rear_word = rear_word | cell_q[DEPTH-1].word;
  end

  assign front = cell_q[0];
  assign empty = !cell_q[0].valid;
  assign full  = cell_q[DEPTH-1].valid;

endmodule

// File: hw/rtl/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input word_t       in_push_value,
  input logic        out_strobe,
  input word_t       out_result_value,
  input logic [1:0]  out_status,
  input logic        out_last_of_run
);

  `ASSERT_CLK(a_push_pop_one_beat, (start && !busy && (in_opcode == OP_PUSH_FRONT || in_opcode == OP_PUSH_REAR || in_opcode == OP_POP_FRONT || in_opcode == OP_POP_REAR)) |=> (out_strobe && out_last_of_run), "push or pop gave no single result")
  `ASSERT_CLK(a_list_streams, busy |=> out_strobe, "list walk skipped a beat")
  `ASSERT_CLK(a_error_is_last, (out_strobe && out_status != ST_OK) |-> (out_last_of_run && out_result_value == '0), "status beat not final or nonzero")
  `ASSERT_CLK(a_status_legal, out_strobe |-> (out_status != 2'd3), "undefined status code")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
